### hdl/json_string_unescape_unit_defines.svh
// Assertion macros shared by the JSON string unescape unit.
// Used by jsu_front, jsu_queue and jsu_back; relies on i_clk and i_rst_n in the including scope.
`ifndef JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UNIT_DEFINES_SVH

// Implication checked in the same cycle, ignored while reset is applied
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle, ignored while reset is applied
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/jsu_pkg.sv
// Shared types for the JSON string unescape unit.
// No dependencies; used by jsu_front, jsu_queue, jsu_back and the top level.
`default_nettype none

package jsu_pkg;

    // Command from the front to the back: one to three result transfers
    typedef struct packed {
        logic [1:0] count;   // number of results, 1 to 3
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       has_byte;
        logic       done;
        logic       bad;
    } t_cmd;

endpackage

`default_nettype wire

### hdl/jsu_front.sv
// Front end: accepts header bytes, runs the string parser, builds result commands.
// Depends on jsu_pkg and json_string_unescape_unit_defines.svh.
`default_nettype none
`include "json_string_unescape_unit_defines.svh"

module jsu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_end,
    input  wire logic          i_q_full,
    output logic               o_push,
    output jsu_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX
    } t_mode;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] LEAD2    = 8'hc0;
    localparam logic [7:0] LEAD3    = 8'he0;
    localparam logic [7:0] CONT     = 8'h80;

    t_mode        r_mode, n_mode;
    logic [1:0]   r_hex_cnt, n_hex_cnt;
    logic [11:0]  r_code, n_code;
    logic         w_acc;
    logic         w_gen;
    logic         w_is_hex;
    logic [3:0]   w_digit;
    logic [15:0]  w_cp;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign o_push  = w_acc && w_gen;

    // Decode a hex digit of either case
    always_comb begin
        w_is_hex = 1'b1;
        w_digit  = 4'd0;
        if (i_byte inside {[8'h30:8'h39]}) begin
            w_digit = i_byte[3:0];
        end else if (i_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            w_digit = i_byte[3:0] + 4'd9;
        end else begin
            w_is_hex = 1'b0;
        end
    end

    assign w_cp = {r_code, w_digit};

    // Parser next state and result command
    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_code    = r_code;
        w_gen     = 1'b0;
        o_cmd     = '0;
        if (i_end) begin
            n_mode = MODE_IDLE; n_hex_cnt = 2'd0; n_code = '0;
            w_gen = 1'b1; o_cmd.count = 2'd1; o_cmd.bad = 1'b1;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    if (i_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                        n_mode = MODE_IDLE;
                    end else if (i_byte == CH_QUOTE) begin
                        n_mode = MODE_BODY;
                    end else begin
                        w_gen = 1'b1; o_cmd.count = 2'd1; o_cmd.bad = 1'b1;
                    end
                end
                MODE_BODY: begin
                    if (i_byte == CH_QUOTE) begin
                        n_mode = MODE_IDLE; n_hex_cnt = 2'd0; n_code = '0;
                        w_gen = 1'b1; o_cmd.count = 2'd1; o_cmd.done = 1'b1;
                    end else if (i_byte == CH_BSL) begin
                        n_mode = MODE_ESC;
                    end else if (i_byte < CH_SPACE) begin
                        n_mode = MODE_IDLE; n_hex_cnt = 2'd0; n_code = '0;
                        w_gen = 1'b1; o_cmd.count = 2'd1; o_cmd.bad = 1'b1;
                    end else begin
                        w_gen = 1'b1; o_cmd.count = 2'd1;
                        o_cmd.has_byte = 1'b1; o_cmd.byte0 = i_byte;
                    end
                end
                MODE_ESC: begin
                    w_gen = 1'b1; o_cmd.count = 2'd1; o_cmd.has_byte = 1'b1;
                    n_mode = MODE_BODY;
                    case (i_byte)
                        CH_QUOTE: o_cmd.byte0 = CH_QUOTE;
                        CH_BSL:   o_cmd.byte0 = CH_BSL;
                        CH_SLASH: o_cmd.byte0 = CH_SLASH;
                        CH_B:     o_cmd.byte0 = CH_BS;
                        CH_F:     o_cmd.byte0 = CH_FF;
                        CH_N:     o_cmd.byte0 = CH_LF;
                        CH_R:     o_cmd.byte0 = CH_CR;
                        CH_T:     o_cmd.byte0 = CH_TAB;
                        CH_U: begin
                            w_gen = 1'b0; o_cmd = '0;
                            n_mode = MODE_HEX; n_hex_cnt = 2'd0; n_code = '0;
                        end
                        default: begin
                            o_cmd = '0; o_cmd.count = 2'd1; o_cmd.bad = 1'b1;
                            n_mode = MODE_IDLE; n_hex_cnt = 2'd0; n_code = '0;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (!w_is_hex) begin
                        n_mode = MODE_IDLE; n_hex_cnt = 2'd0; n_code = '0;
                        w_gen = 1'b1; o_cmd.count = 2'd1; o_cmd.bad = 1'b1;
                    end else if (r_hex_cnt == 2'd3) begin
                        // Fourth digit: encode the code point as UTF-8
                        n_mode = MODE_BODY; n_hex_cnt = 2'd0; n_code = '0;
                        w_gen = 1'b1; o_cmd.has_byte = 1'b1;
                        if (w_cp < 16'h0080) begin
                            o_cmd.count = 2'd1;
                            o_cmd.byte0 = w_cp[7:0];
                        end else if (w_cp < 16'h0800) begin
                            o_cmd.count = 2'd2;
                            o_cmd.byte0 = LEAD2 | {3'b000, w_cp[10:6]};
                            o_cmd.byte1 = CONT | {2'b00, w_cp[5:0]};
                        end else begin
                            o_cmd.count = 2'd3;
                            o_cmd.byte0 = LEAD3 | {4'b0000, w_cp[15:12]};
                            o_cmd.byte1 = CONT | {2'b00, w_cp[11:6]};
                            o_cmd.byte2 = CONT | {2'b00, w_cp[5:0]};
                        end
                    end else begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                        n_code    = w_cp[11:0];
                    end
                end
                default: begin
                    n_mode = MODE_IDLE; n_hex_cnt = 2'd0; n_code = '0;
                end
            endcase
        end
    end

    // Hold parser state; advance on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_hex_cnt <= 2'd0;
            r_code    <= '0;
        end else if (w_acc) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_code    <= n_code;
        end
    end

    `JSU_ASSERT_IMPL(a_front_cmd_count, o_push, o_cmd.count != 2'd0, "front pushed empty command")
    `JSU_ASSERT_IMPL(a_front_hex_idle, r_mode != MODE_HEX, r_hex_cnt == 2'd0 && r_code == '0, "hex state left dirty")

endmodule

`default_nettype wire

### hdl/jsu_queue.sv
// Command queue between the parser front and the output back end.
// Depends on jsu_pkg and json_string_unescape_unit_defines.svh.
`default_nettype none
`include "json_string_unescape_unit_defines.svh"

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  jsu_pkg::t_cmd      i_push_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_head_valid,
    output jsu_pkg::t_cmd      o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_cmd   r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!w_push && w_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `JSU_ASSERT_IMPL(a_queue_no_overflow, i_push, !o_full, "push into full queue")
    `JSU_ASSERT_IMPL(a_queue_no_underflow, i_pop, o_head_valid, "pop from empty queue")

endmodule

`default_nettype wire

### hdl/jsu_back.sv
// Back end: expands queued commands into result transfers through an output register.
// Depends on jsu_pkg and json_string_unescape_unit_defines.svh.
`default_nettype none
`include "json_string_unescape_unit_defines.svh"

module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_head_valid,
    input  jsu_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_byte_valid,
    output logic               o_done,
    output logic               o_bad,
    output logic               o_last
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_byte_valid;
    logic        r_done;
    logic        r_bad;
    logic        r_last;
    logic        w_take;
    logic        w_emit;
    logic        w_final;
    logic [7:0]  w_sel;

    assign w_take  = !r_valid || i_ready;
    assign w_emit  = w_take && i_head_valid;
    assign w_final = (r_idx == i_head.count - 2'd1);
    assign o_pop   = w_emit && w_final;

    // Pick the byte for the current result
    always_comb begin
        case (r_idx)
            2'd0:    w_sel = i_head.byte0;
            2'd1:    w_sel = i_head.byte1;
            default: w_sel = i_head.byte2;
        endcase
    end

    // Result index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_idx <= w_final ? 2'd0 : r_idx + 2'd1;
            end
            if (w_take) begin
                r_valid <= i_head_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte       <= w_sel;
            r_byte_valid <= i_head.has_byte;
            r_done       <= i_head.done;
            r_bad        <= i_head.bad;
            r_last       <= w_final;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_done       = r_done;
    assign o_bad        = r_bad;
    assign o_last       = r_last;

    `JSU_ASSERT_IMPL(a_back_head_held, r_idx != 2'd0, i_head_valid, "command lost mid-expansion")
    `JSU_ASSERT_IMPL(a_back_idx_range, i_head_valid, r_idx < i_head.count, "result index past count")

endmodule

`default_nettype wire

### hdl/json_string_unescape_unit.sv
// JSON string unescape unit: decodes one JSON string from a byte stream to UTF-8 bytes.
// One header byte is accepted per cycle while the queue is not full. A parser front end
// classifies each byte and queues a command of one to three results; the back end sends one
// result per cycle while the receiver is ready, through an output register, so a \u escape
// giving 2 or 3 UTF-8 bytes holds the output port for each of those bytes and the queue of
// QUEUE_DEPTH commands absorbs the difference. Every other byte yields at most one result.
// Whitespace, opening quotes, backslashes and non-final hex digits produce no result. An
// accepted input reaches its first result transfer through the queue and then the output register.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`default_nettype none

module json_string_unescape_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] buffer_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]       m_axis_tuser,   // [0] byte_valid, [1] string_done, [2] malformed
    output logic             m_axis_tlast
);

    logic           w_push;
    jsu_pkg::t_cmd  w_push_cmd;
    logic           w_full;
    logic           w_pop;
    logic           w_head_valid;
    jsu_pkg::t_cmd  w_head;
    logic           w_byte_valid;
    logic           w_done;
    logic           w_bad;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tuser[0]),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_data  (w_push_cmd),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_byte_valid (w_byte_valid),
        .o_done       (w_done),
        .o_bad        (w_bad),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = {w_bad, w_done, w_byte_valid};

endmodule

`default_nettype wire

### test/json_string_unescape_unit_tb.sv
// Testbench for json_string_unescape_unit: drives header bytes and checks the decoded results.
// Stimulus is a directed table then random strings; expectations are typed rows or predicted.
// Depends only on the RTL of json_string_unescape_unit.
`timescale 1ns / 100ps

module json_string_unescape_unit_tb;

    // Character codes the decoder reacts to
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Bit positions in m_axis_tuser
    localparam int USER_VALID = 0;
    localparam int USER_DONE  = 1;
    localparam int USER_BAD   = 2;

    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_AT     = 200;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX
    } t_parse_mode;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_EVERY3
    } t_stall_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic       bad;
        logic       last;
    } t_unesc_result;

    typedef struct packed {
        logic [7:0]    data;
        logic          eob;
        logic          typed;
        t_unesc_result want;
        logic          drain;
    } t_header_item;

    // Directed rows: byte, buffer end, typed, then the typed result (byte, valid, done, bad)
    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        logic       typed;
        logic [7:0] xbyte;
        logic       xvalid;
        logic       xdone;
        logic       xbad;
    } t_dir_row;

    localparam t_dir_row DIRECTED [26] = '{
        '{8'h00,    1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},  // buffer end while idle
        '{CH_SPACE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // whitespace skipped
        '{CH_TAB,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_CR,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_LF,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{8'h78,    1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},  // stray byte while idle
        '{CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // open
        '{8'h20,    1'b0, 1'b1, 8'h20, 1'b1, 1'b0, 1'b0},  // lowest plain byte
        '{8'hff,    1'b0, 1'b1, 8'hff, 1'b1, 1'b0, 1'b0},  // highest plain byte
        '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_N,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // newline escape
        '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_U,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_ZERO,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_ZERO,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_ZERO,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_ZERO,  1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0},  // code point zero gives byte 0
        '{CH_BSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_U,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{8'h64,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // lone surrogate, mixed case
        '{8'h38,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{8'h46,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{8'h66,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{CH_QUOTE, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0},  // close
        '{CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // open again
        '{8'h1f,    1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1}   // control byte in body
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic [0:0] s_axis_tuser = 1'b0;    // [0] buffer_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [2:0] m_axis_tuser;           // [0] byte_valid, [1] string_done, [2] malformed
    logic       m_axis_tlast;

    json_string_unescape_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_header_item  header_q[$];
    t_unesc_result decoded_q[$];
    t_unesc_result step_q[$];

    // Predictor state
    t_parse_mode mode_r = MODE_IDLE;
    logic [1:0]  hex_seen_r = 2'd0;
    logic [15:0] code_r = 16'd0;

    int err_count   = 0;
    int accepted_in = 0;
    int gen_count   = 0;
    int cycle_count = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    task automatic push_step(input logic [7:0] b, input logic v, input logic d, input logic e);
        step_q.push_back('{data: b, valid: v, done: d, bad: e, last: 1'b0});
    endtask

    task automatic go_idle();
        mode_r = MODE_IDLE;
        hex_seen_r = 2'd0;
        code_r = 16'd0;
    endtask

    task automatic flag_malformed();
        go_idle();
        push_step(8'h00, 1'b0, 1'b0, 1'b1);
    endtask

    // Advance the decoder state by one header byte; results land in step_q
    task automatic unescape_predict(input logic [7:0] c, input logic eob);
        logic [15:0] cp;
        int          d;
        step_q.delete();
        if (eob) begin
            flag_malformed();
        end else begin
            case (mode_r)
                MODE_IDLE: begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                        // skip whitespace
                    end else if (c == CH_QUOTE) begin
                        mode_r = MODE_BODY;
                    end else begin
                        flag_malformed();
                    end
                end
                MODE_BODY: begin
                    if (c == CH_QUOTE) begin
                        go_idle();
                        push_step(8'h00, 1'b0, 1'b1, 1'b0);
                    end else if (c == CH_BSLASH) begin
                        mode_r = MODE_ESC;
                    end else if (c < 8'h20) begin
                        flag_malformed();
                    end else begin
                        push_step(c, 1'b1, 1'b0, 1'b0);
                    end
                end
                MODE_ESC: begin
                    mode_r = MODE_BODY;
                    case (c)
                        CH_QUOTE:  push_step(CH_QUOTE, 1'b1, 1'b0, 1'b0);
                        CH_BSLASH: push_step(CH_BSLASH, 1'b1, 1'b0, 1'b0);
                        CH_SLASH:  push_step(CH_SLASH, 1'b1, 1'b0, 1'b0);
                        CH_B:      push_step(8'h08, 1'b1, 1'b0, 1'b0);
                        CH_F:      push_step(8'h0c, 1'b1, 1'b0, 1'b0);
                        CH_N:      push_step(8'h0a, 1'b1, 1'b0, 1'b0);
                        CH_R:      push_step(8'h0d, 1'b1, 1'b0, 1'b0);
                        CH_T:      push_step(8'h09, 1'b1, 1'b0, 1'b0);
                        CH_U: begin
                            mode_r = MODE_HEX;
                            hex_seen_r = 2'd0;
                            code_r = 16'd0;
                        end
                        default:   flag_malformed();
                    endcase
                end
                default: begin
                    d = hex_value(c);
                    if (d < 0) begin
                        flag_malformed();
                    end else if (hex_seen_r != 2'd3) begin
                        code_r = {code_r[11:0], d[3:0]};
                        hex_seen_r = hex_seen_r + 2'd1;
                    end else begin
                        // Fourth digit: emit the code point as UTF-8
                        cp = {code_r[11:0], d[3:0]};
                        if (cp < 16'h0080) begin
                            push_step(cp[7:0], 1'b1, 1'b0, 1'b0);
                        end else if (cp < 16'h0800) begin
                            push_step(8'hc0 | 8'(cp >> 6), 1'b1, 1'b0, 1'b0);
                            push_step(8'h80 | 8'(cp & 16'h3f), 1'b1, 1'b0, 1'b0);
                        end else begin
                            push_step(8'he0 | 8'(cp >> 12), 1'b1, 1'b0, 1'b0);
                            push_step(8'h80 | 8'((cp >> 6) & 16'h3f), 1'b1, 1'b0, 1'b0);
                            push_step(8'h80 | 8'(cp & 16'h3f), 1'b1, 1'b0, 1'b0);
                        end
                        mode_r = MODE_BODY;
                        hex_seen_r = 2'd0;
                        code_r = 16'd0;
                    end
                end
            endcase
        end
        if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
    endtask

    // Stimulus helpers
    task automatic add_item(input logic [7:0] c, input logic eob, input bit counted);
        t_header_item it;
        it = '0;
        it.data = c;
        it.eob = eob;
        it.drain = (gen_count == DRAIN_AT);
        header_q.push_back(it);
        if (counted) gen_count++;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B || c == CH_F
            || c == CH_N || c == CH_R || c == CH_T || c == CH_U;
    endfunction

    task automatic add_unicode(input logic [15:0] cp, input int digits);
        add_item(CH_BSLASH, 1'b0, 1'b1);
        add_item(CH_U, 1'b0, 1'b1);
        for (int k = 3; k > 3 - digits; k--) add_item(hex_char(cp[4*k +: 4]), 1'b0, 1'b1);
    endtask

    task automatic add_simple_escape();
        logic [7:0] letters [8];
        letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
        add_item(CH_BSLASH, 1'b0, 1'b1);
        add_item(letters[$urandom_range(0, 7)], 1'b0, 1'b1);
    endtask

    task automatic add_body(input int len);
        int kind;
        for (int k = 0; k < len; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                add_item(plain_char(), 1'b0, 1'b1);
            end else if (kind < 7) begin
                add_simple_escape();
            end else begin
                case ($urandom_range(0, 2))
                    0: add_unicode(16'($urandom_range(0, 16'h7f)), 4);
                    1: add_unicode(16'($urandom_range(16'h80, 16'h7ff)), 4);
                    default: add_unicode(16'($urandom_range(16'h800, 16'hffff)), 4);
                endcase
            end
        end
    endtask

    // Build the stimulus, reset, then send every header byte
    initial begin
        logic [7:0]   ws [4];
        logic [7:0]   c;
        t_header_item it;
        int           r;
        int           burst_left;
        int           gap;

        ws = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        foreach (DIRECTED[i]) begin
            it = '0;
            it.data = DIRECTED[i].data;
            it.eob = DIRECTED[i].eob;
            it.typed = DIRECTED[i].typed;
            it.want = '{data: DIRECTED[i].xbyte, valid: DIRECTED[i].xvalid,
                        done: DIRECTED[i].xdone, bad: DIRECTED[i].xbad, last: 1'b1};
            header_q.push_back(it);
        end

        while (gen_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            repeat ($urandom_range(0, 2)) add_item(ws[$urandom_range(0, 3)], 1'b0, 1'b0);
            if (r < 70) begin
                // well-formed string
                add_item(CH_QUOTE, 1'b0, 1'b1);
                add_body($urandom_range(0, 8));
                add_item(CH_QUOTE, 1'b0, 1'b1);
            end else if (r < 88) begin
                // string broken by one fault
                add_item(CH_QUOTE, 1'b0, 1'b1);
                add_body($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0: add_item(8'($urandom_range(0, 31)), 1'b0, 1'b1);
                    1: begin
                        do c = 8'($urandom); while (is_escape_letter(c));
                        add_item(CH_BSLASH, 1'b0, 1'b1);
                        add_item(c, 1'b0, 1'b1);
                    end
                    2: begin
                        do c = 8'($urandom); while (hex_value(c) >= 0);
                        add_unicode(16'($urandom), $urandom_range(0, 3));
                        add_item(c, 1'b0, 1'b1);
                    end
                    default: begin
                        // end of buffer in body, after a backslash, or inside \u
                        case ($urandom_range(0, 2))
                            0: ;
                            1: add_item(CH_BSLASH, 1'b0, 1'b1);
                            default: add_unicode(16'($urandom), $urandom_range(0, 3));
                        endcase
                        add_item(8'($urandom), 1'b1, 1'b1);
                    end
                endcase
            end else begin
                // noise
                repeat ($urandom_range(1, 4)) add_item(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        burst_left = 0;
        while (header_q.size() != 0) begin
            it = header_q.pop_front();
            // pause until every pending result has come out
            if (it.drain) begin
                s_axis_tvalid = 1'b0;
                while (decoded_q.size() != 0) @(negedge i_clk);
            end
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_axis_tvalid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            s_axis_tvalid = 1'b1;
            s_axis_tdata = it.data;
            s_axis_tuser = it.eob;
            do @(posedge i_clk); while (!s_axis_tready);
            unescape_predict(it.data, it.eob);
            if (it.typed) begin
                decoded_q.push_back(it.want);
            end else begin
                foreach (step_q[k]) decoded_q.push_back(step_q[k]);
            end
            accepted_in++;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b0;

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS json_string_unescape_unit");
        else
            $display("FAIL json_string_unescape_unit");
        $finish;
    end

    // Receiver: stall on shifting patterns, with one long hold-off to back up the block
    initial begin
        t_stall_mode stall_mode;
        int          left;
        int          hold;
        int          phase;
        bit          hold_used;

        stall_mode = STALL_NONE;
        left = 0;
        hold = 0;
        phase = 0;
        hold_used = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_used && accepted_in >= HOLD_AT) begin
                hold_used = 1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else begin
                if (left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    left = $urandom_range(20, 80);
                end
                left--;
                phase++;
                case (stall_mode)
                    STALL_NONE:  m_axis_tready = 1'b1;
                    STALL_HALF:  m_axis_tready = 1'($urandom_range(0, 1));
                    STALL_HEAVY: m_axis_tready = ($urandom_range(0, 4) == 0);
                    default:     m_axis_tready = (phase % 3 == 0);
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest pending expectation
    always @(posedge i_clk) begin
        t_unesc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte 0x%0h user 0x%0h",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = decoded_q.pop_front();
                check_field("out_byte", m_axis_tdata, want.data);
                check_field("byte_valid", m_axis_tuser[USER_VALID], want.valid);
                check_field("string_done", m_axis_tuser[USER_DONE], want.done);
                check_field("malformed", m_axis_tuser[USER_BAD], want.bad);
                check_field("last", m_axis_tlast, want.last);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL json_string_unescape_unit");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_unit.sv
test/json_string_unescape_unit_tb.sv
